// File: rtl/fvd_pkg.sv
// Shared constants, mode codes and word types of the feature vector distance block.
package fvd_pkg;

	localparam int ELEM_W     = 16;                      // element width, signed Q7.8
	localparam int SUM_W_DEF  = 48;                      // default accumulator width, Q.16
	localparam int DIST_W     = 48;                      // distance field, unsigned Q32.16
	localparam int FRAC_SHIFT = 8;                       // Q.8 input to Q.16 term scaling
	localparam int TERM_W     = 2 * ELEM_W + FRAC_SHIFT; // widest term: scaled quotient
	localparam int CNT_W      = $clog2(TERM_W);          // step counter for the serial units

	typedef enum logic [1:0] {
		MODE_L1  = 2'd0,
		MODE_L2  = 2'd1,
		MODE_CHI = 2'd2,
		MODE_BAD = 2'd3
	} dist_mode_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] elem_a;
		logic signed [ELEM_W-1:0] elem_b;
		logic                     last_elem;
	} in_word_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              overflow;
		logic              bad_mode;
	} out_word_t;

endpackage

// File: rtl/feature_vector_distance_top.sv
// Feature vector distance accumulator (L1, squared L2, chi-squared) with serial multiply/divide.
// Per word: L1 and unsupported mode go straight to the accumulate state, squared L2 multiplies
// first, chi-squared multiplies then divides; a non-positive denominator skips both.
// The shift-add squarer (one multiplier bit per cycle) and the restoring divider (one quotient
// bit per cycle) run serially; a last word waits until the output register takes its result.
// Reset (arst_n low, asynchronous) clears mode, running sum, sticky flag and the output valid.
module feature_vector_distance_top #(
	parameter int SUM_WIDTH = fvd_pkg::SUM_W_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// element pair channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  fvd_pkg::in_word_t    in_data,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output fvd_pkg::out_word_t   out_data,
	// mode register write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_data
);

	localparam int W     = fvd_pkg::ELEM_W;
	localparam int TW    = fvd_pkg::TERM_W;
	localparam int CW    = fvd_pkg::CNT_W;
	localparam int EXT_W = ((TW > SUM_WIDTH) ? TW : SUM_WIDTH) + 1;
	localparam int RES_W = (SUM_WIDTH > fvd_pkg::DIST_W) ? SUM_WIDTH : fvd_pkg::DIST_W;
	localparam logic [SUM_WIDTH-1:0] SUM_MAX = {SUM_WIDTH{1'b1}};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_ACC
	} state_t;

	state_t                 state_q;
	fvd_pkg::dist_mode_t    mode_q;
	logic [SUM_WIDTH-1:0]   sum_q;
	logic                   sticky_q;
	logic                   out_valid_q;
	fvd_pkg::out_word_t     out_data_q;

	// per-word datapath registers
	logic [W-1:0]           mcand_q;   // |a-b|
	logic [W:0]             den_q;     // a+b+1, two's complement
	logic [2*W-1:0]         prod_q;    // squarer: partial product / multiplier bits
	logic [TW-1:0]          work_q;    // term, or dividend shifting out / quotient shifting in
	logic [W-1:0]           rem_q;     // divider partial remainder
	logic [CW-1:0]          cnt_q;
	logic                   last_q;
	logic                   sat_q;     // chi-squared denominator not positive

	// ---------------------------------------------------------------- accept stage
	logic           accept;
	logic [W:0]     ea_x, eb_x, diff, diff_abs, den;
	logic           den_pos;

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;

	always_comb begin
		ea_x     = {in_data.elem_a[W-1], in_data.elem_a};
		eb_x     = {in_data.elem_b[W-1], in_data.elem_b};
		diff     = ea_x - eb_x;
		diff_abs = diff[W] ? (~diff + {{W{1'b0}}, 1'b1}) : diff;
		den      = ea_x + eb_x + {{W{1'b0}}, 1'b1};
		den_pos  = !den[W] && (den != '0);
	end

	// ---------------------------------------------------------------- serial squarer step
	// Add the multiplicand into the upper half when the low multiplier bit is set, then shift.
	logic [W:0]     mul_hi;
	logic [2*W-1:0] prod_next;

	always_comb begin
		mul_hi    = {1'b0, prod_q[2*W-1:W]} + (prod_q[0] ? {1'b0, mcand_q} : '0);
		prod_next = {mul_hi, prod_q[W-1:1]};
	end

	// ---------------------------------------------------------------- restoring divider step
	logic [W:0] trial, trial_sub;
	logic       q_bit;

	always_comb begin
		trial     = {rem_q, work_q[TW-1]};
		trial_sub = trial - {1'b0, den_q[W-1:0]};
		q_bit     = (trial >= {1'b0, den_q[W-1:0]});
	end

	// ---------------------------------------------------------------- accumulate and result
	logic [EXT_W-1:0]     acc_ext;
	logic                 acc_ovf;
	logic [SUM_WIDTH-1:0] sum_next;
	logic                 sticky_next;
	logic [SUM_WIDTH-1:0] res_sum;
	logic [RES_W-1:0]     res_ext;
	fvd_pkg::out_word_t   result;
	logic                 out_free;
	logic                 emit;

	always_comb begin
		acc_ext     = EXT_W'(sum_q) + EXT_W'(work_q);
		acc_ovf     = (acc_ext[EXT_W-1:SUM_WIDTH] != '0);
		sum_next    = sum_q;
		sticky_next = sticky_q;
		if (mode_q != fvd_pkg::MODE_BAD) begin
			if (sat_q || acc_ovf) begin
				sum_next    = SUM_MAX;
				sticky_next = 1'b1;
			end else begin
				sum_next = acc_ext[SUM_WIDTH-1:0];
			end
		end
		// chi-squared keeps the unhalved sum; halve on the way out
		res_sum = (mode_q == fvd_pkg::MODE_CHI) ? (sum_next >> 1) : sum_next;
		res_ext = RES_W'(res_sum);
		if (mode_q == fvd_pkg::MODE_BAD) begin
			result.distance = '0;
			result.overflow = 1'b0;
			result.bad_mode = 1'b1;
		end else begin
			result.distance = res_ext[fvd_pkg::DIST_W-1:0];
			result.overflow = sticky_next;
			result.bad_mode = 1'b0;
		end
		out_free = !out_valid_q || !out_stall;
		emit     = (state_q == ST_ACC) && last_q && out_free;
	end

	// ---------------------------------------------------------------- control and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= fvd_pkg::MODE_L1;
			sum_q       <= '0;
			sticky_q    <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_q <= fvd_pkg::dist_mode_t'(cfg_data);
			end
			// load a new output word, else drop the current one once taken
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (mode_q)
							fvd_pkg::MODE_L2:  state_q <= ST_MUL;
							fvd_pkg::MODE_CHI: state_q <= den_pos ? ST_MUL : ST_ACC;
							default:           state_q <= ST_ACC;
						endcase
					end
				end
				ST_MUL: begin
					if (cnt_q == '0) begin
						state_q <= (mode_q == fvd_pkg::MODE_CHI) ? ST_DIV : ST_ACC;
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					// hold a last word until the output register can take the result
					if (!last_q) begin
						sum_q    <= sum_next;
						sticky_q <= sticky_next;
						state_q  <= ST_IDLE;
					end else if (out_free) begin
						sum_q       <= '0;
						sticky_q    <= 1'b0;
						out_data_q  <= result;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------- datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					mcand_q <= diff_abs[W-1:0];
					den_q   <= den;
					prod_q  <= {{W{1'b0}}, diff_abs[W-1:0]};
					work_q  <= TW'({diff_abs[W-1:0], {fvd_pkg::FRAC_SHIFT{1'b0}}});
					cnt_q   <= CW'(W - 1);
					last_q  <= in_data.last_elem;
					sat_q   <= (mode_q == fvd_pkg::MODE_CHI) && !den_pos;
				end
			end
			ST_MUL: begin
				prod_q <= prod_next;
				if (cnt_q == '0) begin
					// squared L2 takes the product as is; chi-squared divides it scaled by 256
					if (mode_q == fvd_pkg::MODE_CHI) begin
						work_q <= {prod_next, {fvd_pkg::FRAC_SHIFT{1'b0}}};
					end else begin
						work_q <= TW'(prod_next);
					end
					rem_q <= '0;
					cnt_q <= CW'(TW - 1);
				end else begin
					cnt_q <= cnt_q - {{(CW-1){1'b0}}, 1'b1};
				end
			end
			ST_DIV: begin
				rem_q  <= q_bit ? trial_sub[W-1:0] : trial[W-1:0];
				work_q <= {work_q[TW-2:0], q_bit};
				cnt_q  <= cnt_q - {{(CW-1){1'b0}}, 1'b1};
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// ---------------------------------------------------------------- assertions
	// the partial remainder stays below the divisor through every divide step
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < den_q[W-1:0]))
		else $error("divider remainder not below divisor");

	// a new result word appears only when a last word finishes accumulation
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_ACC && last_q))
		else $error("result word without a finished last element");

	// emitting a result clears the running sum and the sticky flag
	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC && last_q && out_free) |=> (sum_q == '0 && !sticky_q))
		else $error("running state not cleared after result");

	// an unsupported-mode result carries zero distance and no overflow
	a_bad_mode_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.bad_mode) |->
			(out_data_q.distance == '0 && !out_data_q.overflow))
		else $error("unsupported-mode result not zero");

endmodule

// File: bench/fvd_distance_checker.sv
`timescale 1ns / 1ps
// Channel monitor for the feature vector distance block: predicts each distance word and compares.
module fvd_distance_checker #(
	parameter int SUM_WIDTH = fvd_pkg::SUM_W_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  fvd_pkg::in_word_t  in_data,
	input  logic               out_valid,
	input  logic               out_stall,
	input  fvd_pkg::out_word_t out_data,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [1:0]         cfg_data,
	output int                 fail_count,
	output int                 pending,
	output int                 checked
);

	localparam longint unsigned SUM_MAX    = {64{1'b1}} >> (64 - SUM_WIDTH);
	localparam longint unsigned QUOT_LIMIT = 64'd1 << 56;

	fvd_pkg::dist_mode_t mode_now;
	longint unsigned     acc_sum;
	bit                  acc_sticky;
	fvd_pkg::out_word_t  pending_distances[$];
	int                  fails;
	int                  reports;
	int                  checked_n;

	function automatic void saturate_acc();
		acc_sum    = SUM_MAX;
		acc_sticky = 1'b1;
	endfunction

	function automatic void add_term(longint unsigned t);
		if (t > SUM_MAX - acc_sum) begin
			saturate_acc();
		end else begin
			acc_sum += t;
		end
	endfunction

	// Fold one element pair into the running sum; queue a distance on the last element.
	function automatic void fold_pair(fvd_pkg::in_word_t w);
		longint             a, b, dif, den;
		longint unsigned    mag, sq, q, r, dv, dist_full;
		fvd_pkg::out_word_t res;
		a   = $signed(w.elem_a);
		b   = $signed(w.elem_b);
		dif = a - b;
		mag = (dif < 0) ? -dif : dif;
		sq  = mag * mag;
		case (mode_now)
			fvd_pkg::MODE_L1: add_term(mag << fvd_pkg::FRAC_SHIFT);
			fvd_pkg::MODE_L2: add_term(sq);
			fvd_pkg::MODE_CHI: begin
				den = a + b + 1;
				if (den <= 0) begin
					saturate_acc();
				end else begin
					dv = den;
					q  = sq / dv;
					r  = sq % dv;
					if (q >= QUOT_LIMIT) begin
						saturate_acc();
					end else begin
						add_term((q << fvd_pkg::FRAC_SHIFT) + (r << fvd_pkg::FRAC_SHIFT) / dv);
					end
				end
			end
			default: ;
		endcase
		if (w.last_elem) begin
			if (mode_now == fvd_pkg::MODE_BAD) begin
				res.distance = '0;
				res.overflow = 1'b0;
				res.bad_mode = 1'b1;
			end else begin
				dist_full    = (mode_now == fvd_pkg::MODE_CHI) ? (acc_sum >> 1) : acc_sum;
				res.distance = dist_full[fvd_pkg::DIST_W-1:0];
				res.overflow = acc_sticky;
				res.bad_mode = 1'b0;
			end
			pending_distances.push_back(res);
			acc_sum    = 0;
			acc_sticky = 1'b0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		fvd_pkg::out_word_t want;
		if (!arst_n) begin
			mode_now   = fvd_pkg::MODE_L1;
			acc_sum    = 0;
			acc_sticky = 1'b0;
			pending_distances.delete();
			fails      = 0;
			reports    = 0;
			checked_n  = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_now = fvd_pkg::dist_mode_t'(cfg_data);
			end
			// a word leaving now belongs to an earlier pair, so compare before folding
			if (out_valid && !out_stall) begin
				if (pending_distances.size() == 0) begin
					fails++;
					if (reports < 10) begin
						$display("%0t: distance word with none expected: d=%h ov=%b bad=%b",
							$realtime, out_data.distance, out_data.overflow, out_data.bad_mode);
					end
					reports++;
				end else begin
					want = pending_distances.pop_front();
					checked_n++;
					if (out_data.distance !== want.distance ||
					    out_data.overflow !== want.overflow ||
					    out_data.bad_mode !== want.bad_mode) begin
						fails++;
						if (reports < 10) begin
							$display("%0t: distance mismatch: want d=%h ov=%b bad=%b",
								$realtime, want.distance, want.overflow, want.bad_mode);
							$display("    got d=%h ov=%b bad=%b",
								out_data.distance, out_data.overflow, out_data.bad_mode);
						end
						reports++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				fold_pair(in_data);
			end
		end
		fail_count <= fails;
		pending    <= pending_distances.size();
		checked    <= checked_n;
	end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Top of the feature vector distance bench: clock, reset, element stimulus, output stalls, verdict.
module tb;

	// cycles to let the block finish a pair that yields no word, chi-squared being the slowest mode
	localparam int DRAIN_CYCLES = 70;
	localparam int RANDOM_PAIRS = 1050;
	localparam int HOLD_CYCLES  = 400;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	fvd_pkg::in_word_t  in_data;
	logic               out_valid;
	logic               out_stall;
	fvd_pkg::out_word_t out_data;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_data;

	int fail_count;
	int pending;
	int checked;

	// knobs the stimulus sets for the sender and the receiver
	int hold_len;
	bit sender_quiet;
	bit receiver_quiet;

	int pairs_sent;
	int vectors_sent;
	int mode_writes;

	feature_vector_distance_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	fvd_distance_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	always #10 clk = ~clk;

	// Drop valid, wait until every expected distance word is out, then let the block settle.
	// The first pending sample is taken at the edge after the last accept, so it already counts it.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write the mode register; only ever done with the block idle.
	task automatic write_mode(fvd_pkg::dist_mode_t m);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		mode_writes++;
	endtask

	// Offer one element pair after a random gap and hold it until the block takes it.
	// Valid is left high on return, so a back-to-back word follows without valid dropping.
	task automatic send_pair(logic signed [fvd_pkg::ELEM_W-1:0] a,
	                         logic signed [fvd_pkg::ELEM_W-1:0] b,
	                         logic last);
		int gap;
		gap = sender_quiet ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{elem_a: a, elem_b: b, last_elem: last};
		do @(posedge clk); while (in_stall);
		pairs_sent++;
		if (last) begin
			vectors_sent++;
		end
	endtask

	// Pick an element: rails, small values or anything; non-negative keeps chi-squared
	// denominators positive so the sum grows instead of saturating on every pair.
	function automatic logic signed [fvd_pkg::ELEM_W-1:0] pick_elem(bit non_negative);
		case ($urandom_range(0, 9))
			0:       return 16'h7fff;
			1:       return non_negative ? 16'h0000 : 16'h8000;
			2:       return 16'($urandom_range(0, 255));
			default: return non_negative ? 16'($urandom_range(0, 32767)) : 16'($urandom);
		endcase
	endfunction

	// Receiver: draw a stall per word, honor a requested long hold, then take the next word.
	initial begin : receiver
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_len > 0) begin
				n        = hold_len;
				hold_len = 0;
			end else begin
				n = receiver_quiet ? 0 : $urandom_range(0, 13);
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			// leave early when a long hold is requested so it starts while words pile up
			do @(posedge clk); while (!out_valid && hold_len == 0);
		end
	end

	initial begin : stimulus
		int                  phase;
		int                  n_vec;
		int                  len;
		bit                  nonneg;
		fvd_pkg::dist_mode_t m;
		clk            = 1'b0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_data        = '0;
		cfg_valid      = 1'b0;
		cfg_data       = fvd_pkg::MODE_L1;
		hold_len       = 0;
		sender_quiet   = 1'b0;
		receiver_quiet = 1'b0;
		pairs_sent     = 0;
		vectors_sent   = 0;
		mode_writes    = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// L1: widest difference both ways, zero, and a two-element vector
		write_mode(fvd_pkg::MODE_L1);
		send_pair(16'sh7fff, 16'sh8000, 1'b1);
		send_pair(16'sh8000, 16'sh7fff, 1'b1);
		send_pair(16'sd0, 16'sd0, 1'b1);
		send_pair(-16'sd1, -16'sd1, 1'b0);
		send_pair(16'sd100, -16'sd100, 1'b1);

		// squared L2: largest square, equal rails
		write_mode(fvd_pkg::MODE_L2);
		send_pair(16'sh8000, 16'sh7fff, 1'b1);
		send_pair(16'sh7fff, 16'sh7fff, 1'b0);
		send_pair(16'sh8000, 16'sh8000, 1'b0);
		send_pair(16'sd1, -16'sd1, 1'b1);

		// chi-squared: denominator one with the widest difference, zero and negative
		// denominators, zero difference, and a term whose quotient the divider truncates
		write_mode(fvd_pkg::MODE_CHI);
		send_pair(16'sh7fff, -16'sh7fff, 1'b1);
		send_pair(-16'sd1, 16'sd0, 1'b1);
		send_pair(16'sh8000, 16'sh8000, 1'b1);
		send_pair(16'sd0, 16'sd0, 1'b1);
		send_pair(16'sh8000, 16'sh7fff, 1'b1);
		send_pair(16'sd3, 16'sd1, 1'b1);

		// mode changes inside a vector: chi-squared then unsupported at the last element
		send_pair(16'sd500, -16'sd500, 1'b0);
		write_mode(fvd_pkg::MODE_BAD);
		send_pair(16'sd7, 16'sd7, 1'b0);
		send_pair(16'sd1, 16'sd2, 1'b1);
		send_pair(16'sh8000, 16'sh7fff, 1'b1);
		// L1 terms then chi-squared at the last element, so the whole sum gets halved
		write_mode(fvd_pkg::MODE_L1);
		send_pair(16'sd10, 16'sd20, 1'b0);
		write_mode(fvd_pkg::MODE_CHI);
		send_pair(16'sd5, 16'sd3, 1'b1);

		// Random phases: one mode setting each, mostly a handful of random vectors, in phase 6 one long fixed one.
		phase = 0;
		while (pairs_sent < RANDOM_PAIRS) begin
			m = (phase < 4) ? fvd_pkg::dist_mode_t'(phase) :
			                  fvd_pkg::dist_mode_t'($urandom_range(0, 3));
			if (phase == 6) begin
				m = fvd_pkg::MODE_CHI;
			end
			write_mode(m);
			sender_quiet   = ($urandom_range(0, 4) == 0);
			receiver_quiet = ($urandom_range(0, 4) == 0);
			if (phase == 2) begin
				// hold the output for a long stretch while pairs keep coming back to back
				hold_len     = HOLD_CYCLES;
				sender_quiet = 1'b1;
			end
			if (phase == 6) begin
				// enough maximal chi-squared terms to drive the sum into saturation
				for (int k = 0; k < 270; k++) begin
					send_pair(16'sh7fff, -16'sh7fff, k == 269);
				end
			end else begin
				n_vec = $urandom_range(2, 8);
				for (int v = 0; v < n_vec; v++) begin
					if (phase == 2) begin
						len = $urandom_range(1, 2);
					end else if ($urandom_range(0, 15) == 0) begin
						len = $urandom_range(20, 40);
					end else begin
						len = $urandom_range(1, 8);
					end
					for (int k = 0; k < len; k++) begin
						nonneg = (m == fvd_pkg::MODE_CHI) && ($urandom_range(0, 4) != 0);
						send_pair(pick_elem(nonneg), pick_elem(nonneg), k == len - 1);
					end
				end
			end
			phase++;
		end

		wait_drained();
		$display("tb: %0d element pairs in %0d vectors, %0d mode writes over all four modes",
			pairs_sent, vectors_sent, mode_writes);
		$display("tb: %0d distance words checked, with a saturating chi-squared run",
			checked);
		$display("tb: and a long output hold");
		if (fail_count == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

	// Guard against a hung handshake: several times the slowest legal run.
	initial begin : watchdog
		#16_000_000;
		$display("tb NOT OK");
		$finish;
	end

endmodule

// File: files.f
rtl/fvd_pkg.sv
rtl/feature_vector_distance_top.sv
bench/fvd_distance_checker.sv
bench/tb.sv
